[rtl/sarxf_pkg.sv]
// Package for the serial adapter with receive FIFO: sizes, codes, status bits,
// controller/datapath link types and the FIFO pointer increment.
// No dependencies.
`timescale 1ns / 1ps

package sarxf_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RECEIVE = 2'd2,
    ACT_POLL    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_DATA    = 2'd0,
    REG_STATUS  = 2'd1,
    REG_COMMAND = 2'd2,
    REG_CONTROL = 2'd3
  } reg_t;

  localparam int STAT_AVAIL_BIT = 3;
  localparam int STAT_ONE_BIT   = 4;
  localparam int STAT_IRQ_BIT   = 7;
  localparam int CMD_IRQ_EN_BIT = 7;

  typedef struct packed {
    logic exec;
    logic mem_load;
  } sarxf_cmd_t;

  typedef struct packed {
    logic pop;
    logic out_valid;
  } sarxf_stat_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

[rtl/serial_adapter_rx_fifo_regs.sv]
// Top level of the serial adapter with receive FIFO: joins the controller
// and the datapath. Uses sarxf_pkg, sarxf_ctrl and sarxf_dpath.
//
//   Channel  Handshake             Word
//   input    in_valid / in_ready   action, reg_index, write_data, rx_byte
//   output   out_valid / out_ready read_data, tx_valid, tx_byte, irq_request,
//                                  rx_dropped
//
// A data register read that pops a byte is loaded from the registered read
// port of the receive store in a later state; other words load when taken.
// A new word is taken when idle and the output register is empty or emptying.
// Synchronous reset empties the FIFO and clears command and interrupt state.
// The store contents are not cleared; only written entries are ever read.
`timescale 1ns / 1ps

module serial_adapter_rx_fifo_regs
  import sarxf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [1:0] reg_index,
  input  logic [7:0] write_data,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       irq_request,
  output logic       rx_dropped
);

  sarxf_cmd_t  cmd;
  sarxf_stat_t stat;

  sarxf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sarxf_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .rx_byte     (rx_byte),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .read_data   (read_data),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .irq_request (irq_request),
    .rx_dropped  (rx_dropped)
  );

endmodule

[rtl/sarxf_ctrl.sv]
// Controller state machine for the serial adapter: input handshake and the
// extra state that a FIFO pop spends on the store read. Uses sarxf_pkg.
`timescale 1ns / 1ps

module sarxf_ctrl
  import sarxf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_ready,
  input  sarxf_stat_t stat,
  output sarxf_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_MEMRD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready     = (state == ST_IDLE) && (!stat.out_valid || out_ready);
    cmd.exec     = in_valid && in_ready;
    cmd.mem_load = (state == ST_MEMRD);
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (cmd.exec && stat.pop) begin
          state_next = ST_MEMRD;
        end
      end
      ST_MEMRD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/sarxf_dpath.sv]
// Datapath for the serial adapter: receive store, pointers, command and
// interrupt flags, and the output word register. Uses sarxf_pkg.
`timescale 1ns / 1ps

module sarxf_dpath
  import sarxf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sarxf_cmd_t  cmd,
  output sarxf_stat_t stat,
  input  logic [1:0]  action,
  input  logic [1:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [7:0]  rx_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        irq_request,
  output logic        rx_dropped
);

  logic [7:0] rx_store [FIFO_DEPTH];
  logic [7:0] mem_q;
  ptr_t       write_pointer;
  ptr_t       read_pointer;
  logic       irq_pending;
  logic [7:0] command_reg;

  ptr_t       wp_inc;
  ptr_t       rp_inc;
  logic       has_data;
  logic       is_read;
  logic       is_write;
  logic       is_rx;
  logic       is_poll;
  logic       push_ok;
  logic       irq_hit;
  logic [7:0] status_byte;
  logic [7:0] rd_now;

  always_comb begin
    wp_inc    = ptr_next(write_pointer);
    rp_inc    = ptr_next(read_pointer);
    has_data  = (write_pointer != read_pointer);
    is_read   = (action == ACT_READ);
    is_write  = (action == ACT_WRITE);
    is_rx     = (action == ACT_RECEIVE);
    is_poll   = (action == ACT_POLL);
    push_ok   = is_rx && (wp_inc != read_pointer);
    irq_hit   = (is_rx || is_poll) && command_reg[CMD_IRQ_EN_BIT] && (has_data || push_ok);
    stat.pop  = is_read && (reg_index == REG_DATA) && has_data;
    stat.out_valid = out_valid;
    status_byte = '0;
    status_byte[STAT_AVAIL_BIT] = has_data;
    status_byte[STAT_ONE_BIT]   = 1'b1;
    status_byte[STAT_IRQ_BIT]   = irq_pending;
    rd_now = (is_read && (reg_index == REG_STATUS)) ? status_byte : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      rx_store[write_pointer] <= rx_byte;
    end
    mem_q <= rx_store[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      irq_pending   <= 1'b0;
      command_reg   <= '0;
    end else if (cmd.exec) begin
      if (stat.pop) begin
        read_pointer <= rp_inc;
        if (rp_inc == write_pointer) begin
          irq_pending <= 1'b0;
        end
      end
      if (is_write && (reg_index == REG_STATUS)) begin
        command_reg   <= '0;
        irq_pending   <= 1'b0;
        write_pointer <= '0;
        read_pointer  <= '0;
      end
      if (is_write && (reg_index == REG_COMMAND)) begin
        command_reg <= write_data;
      end
      if (push_ok) begin
        write_pointer <= wp_inc;
      end
      if (irq_hit) begin
        irq_pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mem_load || (cmd.exec && !stat.pop)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_load) begin
      read_data   <= mem_q;
      tx_valid    <= 1'b0;
      tx_byte     <= 8'h00;
      irq_request <= 1'b0;
      rx_dropped  <= 1'b0;
    end else if (cmd.exec && !stat.pop) begin
      read_data   <= rd_now;
      tx_valid    <= is_write && (reg_index == REG_DATA);
      tx_byte     <= (is_write && (reg_index == REG_DATA)) ? write_data : 8'h00;
      irq_request <= irq_hit;
      rx_dropped  <= is_rx && !push_ok;
    end
  end

endmodule

[rtl/sarxf_checker.sv]
// Port-level checks for the serial adapter with receive FIFO, bound to the
// top level. Uses sarxf_pkg.
`timescale 1ns / 1ps

module sarxf_checker
  import sarxf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] action,
  input logic [1:0] reg_index,
  input logic [7:0] write_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       irq_request,
  input logic       rx_dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_byte))
    else $error("Output word changed while stalled.");

  a_tx_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_WRITE) && (reg_index == REG_DATA)
    |=> out_valid && tx_valid && (tx_byte == $past(write_data)))
    else $error("Data register write did not produce its transmit word.");

  a_tx_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> !irq_request && !rx_dropped && (read_data == 8'h00))
    else $error("Transmit word carries other results.");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> (tx_byte == 8'h00))
    else $error("Transmit byte nonzero without transmit.");

endmodule

bind serial_adapter_rx_fifo_regs sarxf_checker u_sarxf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .action      (action),
  .reg_index   (reg_index),
  .write_data  (write_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_data   (read_data),
  .tx_valid    (tx_valid),
  .tx_byte     (tx_byte),
  .irq_request (irq_request),
  .rx_dropped  (rx_dropped)
);
